@@ hdl/aps_pkg.sv @@
// Shared types and constants for the alignment path scorer.
package aps_pkg;

    typedef enum logic [1:0] {
        KIND_MATCH  = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_INSERT = 2'd2,
        KIND_START  = 2'd3
    } kind_t;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_SCORE = 1'b1
    } op_t;

    localparam int NUM_REGS       = 6;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;

    localparam logic [CFG_INDEX_BITS-1:0] REG_INTERIOR_OPEN   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LEFT_OPEN       = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RIGHT_OPEN      = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_INTERIOR_EXTEND = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LEFT_EXTEND     = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RIGHT_EXTEND    = 3'd5;

    // Penalty register file: each entry holds the A half in 15:0, B half in 31:16
    typedef logic [NUM_REGS-1:0][CFG_DATA_BITS-1:0] cfg_file_t;

    localparam int TOTAL_BITS = 32;

endpackage

@@ hdl/aps_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module aps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/aps_cfg_regs.sv @@
// Penalty configuration register file.
module aps_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [aps_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [aps_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output aps_pkg::cfg_file_t                  regs
);

    import aps_pkg::*;

    cfg_file_t regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg <= '0;
        end
        else if (cfg_we && (32'(cfg_index) < NUM_REGS))
        begin
            regs_reg[cfg_index] <= cfg_data;
        end
    end

    assign regs = regs_reg;

endmodule

@@ hdl/aps_column.sv @@
// Combinational scoring of one path column against the current path state.
module aps_column #(
    parameter int LENGTH_BITS = 16,
    parameter int SCORE_BITS  = 16
) (
    input  aps_pkg::cfg_file_t                  regs,
    input  aps_pkg::kind_t                      prev_kind,
    input  logic [LENGTH_BITS-1:0]              pos_a,
    input  logic [LENGTH_BITS-1:0]              pos_b,
    input  logic signed [aps_pkg::TOTAL_BITS-1:0] total,
    input  logic                                err,
    input  logic [1:0]                          kind,
    input  logic [LENGTH_BITS-1:0]              len_a,
    input  logic [LENGTH_BITS-1:0]              len_b,
    input  logic signed [SCORE_BITS-1:0]        match_value,
    output aps_pkg::kind_t                      prev_kind_next,
    output logic [LENGTH_BITS-1:0]              pos_a_next,
    output logic [LENGTH_BITS-1:0]              pos_b_next,
    output logic signed [aps_pkg::TOTAL_BITS-1:0] total_next,
    output logic                                err_next
);

    import aps_pkg::*;

    localparam int SUM_BITS = TOTAL_BITS + 2;
    localparam logic signed [SUM_BITS-1:0] SAT_MAX = SUM_BITS'(32'sh7FFF_FFFF);
    localparam logic signed [SUM_BITS-1:0] SAT_MIN = SUM_BITS'(32'sh8000_0000);

    // A 16-bit signed penalty wrapped to the score width
    function automatic logic signed [SCORE_BITS-1:0] pen(input logic [15:0] h);
        logic signed [31:0] w;
        begin
            w = 32'(signed'(h));
            return w[SCORE_BITS-1:0];
        end
    endfunction

    function automatic logic signed [SCORE_BITS-1:0] half_a(input logic [31:0] r);
        begin
            return pen(r[15:0]);
        end
    endfunction

    function automatic logic signed [SCORE_BITS-1:0] half_b(input logic [31:0] r);
        begin
            return pen(r[31:16]);
        end
    endfunction

    logic                         ok;
    logic                         left_a;
    logic                         left_b;
    logic                         right_a;
    logic                         right_b;
    logic [LENGTH_BITS-1:0]       ia;
    logic [LENGTH_BITS-1:0]       ib;
    logic signed [SCORE_BITS-1:0] match;
    logic signed [SCORE_BITS-1:0] gap;
    logic signed [SUM_BITS-1:0]   sum;

    always_comb
    begin
        ia     = pos_a;
        ib     = pos_b;
        match  = '0;
        ok     = 1'b0;
        left_a = (pos_a == '0);
        left_b = (pos_b == '0);
        case (kind)
            KIND_MATCH:
            begin
                ok    = (pos_a < len_a) && (pos_b < len_b);
                ia    = pos_a + 1'b1;
                ib    = pos_b + 1'b1;
                match = match_value;
            end
            KIND_DELETE:
            begin
                ok = (pos_a < len_a);
                ia = pos_a + 1'b1;
            end
            KIND_INSERT:
            begin
                ok = (pos_b < len_b);
                ib = pos_b + 1'b1;
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase

        right_a = (len_a != '0) && (ia == len_a);
        right_b = (len_b != '0) && (ib == len_b);

        gap = '0;
        case (prev_kind)
            KIND_START:
            begin
                if (kind == KIND_DELETE)
                    gap = half_b(regs[REG_LEFT_OPEN]);
                else if (kind == KIND_INSERT)
                    gap = half_a(regs[REG_LEFT_OPEN]);
            end
            KIND_MATCH:
            begin
                if (kind == KIND_DELETE)
                    gap = right_b ? half_b(regs[REG_RIGHT_OPEN])
                                  : half_b(regs[REG_INTERIOR_OPEN]);
                else if (kind == KIND_INSERT)
                    gap = right_a ? half_a(regs[REG_RIGHT_OPEN])
                                  : half_a(regs[REG_INTERIOR_OPEN]);
            end
            KIND_DELETE:
            begin
                if (kind == KIND_DELETE)
                    gap = left_b  ? half_b(regs[REG_LEFT_EXTEND]) :
                          right_b ? half_b(regs[REG_RIGHT_EXTEND]) :
                                    half_b(regs[REG_INTERIOR_EXTEND]);
            end
            KIND_INSERT:
            begin
                if (kind == KIND_INSERT)
                    gap = left_a  ? half_a(regs[REG_LEFT_EXTEND]) :
                          right_a ? half_a(regs[REG_RIGHT_EXTEND]) :
                                    half_a(regs[REG_INTERIOR_EXTEND]);
            end
            default:
            begin
                gap = '0;
            end
        endcase

        sum = SUM_BITS'(total) + SUM_BITS'(match) + SUM_BITS'(gap);

        if (ok)
        begin
            prev_kind_next = kind_t'(kind);
            pos_a_next     = ia;
            pos_b_next     = ib;
            err_next       = err;
            if (sum > SAT_MAX)
                total_next = 32'sh7FFF_FFFF;
            else if (sum < SAT_MIN)
                total_next = 32'sh8000_0000;
            else
                total_next = sum[TOTAL_BITS-1:0];
        end
        else
        begin
            // bad kind or overrun: flag it, leave the path where it is
            prev_kind_next = prev_kind;
            pos_a_next     = pos_a;
            pos_b_next     = pos_b;
            err_next       = 1'b1;
            total_next     = total;
        end
    end

endmodule

@@ hdl/alignment_path_scorer.sv @@
// Top level of the alignment path scorer: table, path state and result register.
//
//  channel  | direction | contents
//  ---------+-----------+------------------------------------------------------
//  s_axis   | in        | tuser operation; tlast last_column; tdata column_kind,
//           |           | residue_a, residue_b, length_a, length_b, matrix_value
//  m_axis   | out       | tdata total_score; tuser path_error
//  cfg      | in        | six penalty pair registers, write only
//
// One item per cycle while the input is not stalled. An item is registered together
// with its table read from the table RAM's registered read port, then scored from
// those registers; a path's result passes through the input stage registers into
// the output register after its last column is accepted. Reset clears the path
// state, penalties and control; the table holds no defined contents until loaded.
// The input stalls only while a result waits in the output register.
module alignment_path_scorer #(
    parameter int ALPHABET_BITS = 5,
    parameter int LENGTH_BITS   = 16,
    parameter int SCORE_BITS    = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // column_kind[1:0], residue_a[6:2], residue_b[11:7], length_a[27:12],
    // length_b[43:28], matrix_value[59:44], zero[63:60]
    input  logic [63:0]                         s_axis_tdata,
    // operation[0]
    input  logic                                s_axis_tuser,
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // total_score[31:0]
    output logic [31:0]                         m_axis_tdata,
    // path_error[0]
    output logic                                m_axis_tuser,
    input  logic                                cfg_we,
    input  logic [aps_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [aps_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    import aps_pkg::*;

    localparam int ADDR_BITS = 2 * ALPHABET_BITS;
    localparam int DEPTH     = 1 << ADDR_BITS;

    logic [1:0]  in_kind;
    logic [4:0]  in_res_a;
    logic [4:0]  in_res_b;
    logic [15:0] in_len_a;
    logic [15:0] in_len_b;
    logic [15:0] in_value;
    logic [7:0]  res_a_wide;
    logic [7:0]  res_b_wide;
    logic [31:0] len_a_wide;
    logic [31:0] len_b_wide;
    logic [31:0] value_wide;

    logic                   accept;
    logic                   advance;
    logic [ADDR_BITS-1:0]   tbl_addr;
    logic [SCORE_BITS-1:0]  tbl_rdata;
    logic                   tbl_we;

    // input stage
    logic                   v1_reg;
    op_t                    op1_reg;
    logic [1:0]             kind1_reg;
    logic [LENGTH_BITS-1:0] len_a1_reg;
    logic [LENGTH_BITS-1:0] len_b1_reg;
    logic                   last1_reg;

    // path state
    kind_t                  prev_kind_reg;
    logic [LENGTH_BITS-1:0] pos_a_reg;
    logic [LENGTH_BITS-1:0] pos_b_reg;
    logic signed [TOTAL_BITS-1:0] total_reg;
    logic                   err_reg;

    kind_t                  prev_kind_next;
    logic [LENGTH_BITS-1:0] pos_a_next;
    logic [LENGTH_BITS-1:0] pos_b_next;
    logic signed [TOTAL_BITS-1:0] total_next;
    logic                   err_next;

    // result register
    logic                   out_valid_reg;
    logic [TOTAL_BITS-1:0]  out_total_reg;
    logic                   out_err_reg;

    cfg_file_t              regs;
    logic                   score_col;

    assign in_kind  = s_axis_tdata[1:0];
    assign in_res_a = s_axis_tdata[6:2];
    assign in_res_b = s_axis_tdata[11:7];
    assign in_len_a = s_axis_tdata[27:12];
    assign in_len_b = s_axis_tdata[43:28];
    assign in_value = s_axis_tdata[59:44];

    assign res_a_wide = 8'(in_res_a);
    assign res_b_wide = 8'(in_res_b);
    assign len_a_wide = 32'(in_len_a);
    assign len_b_wide = 32'(in_len_b);
    assign value_wide = 32'(signed'(in_value));

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = advance;
    assign accept        = s_axis_tvalid && advance;
    assign tbl_addr      = {res_a_wide[ALPHABET_BITS-1:0], res_b_wide[ALPHABET_BITS-1:0]};
    assign tbl_we        = accept && (op_t'(s_axis_tuser) == OP_LOAD);

    aps_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .regs      (regs)
    );

    // loads write at acceptance, so a later match always sees them
    aps_ram #(
        .WIDTH (SCORE_BITS),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_addr),
        .wdata (value_wide[SCORE_BITS-1:0]),
        .re    (accept),
        .raddr (tbl_addr),
        .rdata (tbl_rdata)
    );

    aps_column #(
        .LENGTH_BITS (LENGTH_BITS),
        .SCORE_BITS  (SCORE_BITS)
    ) u_column (
        .regs           (regs),
        .prev_kind      (prev_kind_reg),
        .pos_a          (pos_a_reg),
        .pos_b          (pos_b_reg),
        .total          (total_reg),
        .err            (err_reg),
        .kind           (kind1_reg),
        .len_a          (len_a1_reg),
        .len_b          (len_b1_reg),
        .match_value    (signed'(tbl_rdata)),
        .prev_kind_next (prev_kind_next),
        .pos_a_next     (pos_a_next),
        .pos_b_next     (pos_b_next),
        .total_next     (total_next),
        .err_next       (err_next)
    );

    assign score_col = v1_reg && advance && (op1_reg == OP_SCORE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            op1_reg       <= OP_LOAD;
            kind1_reg     <= '0;
            len_a1_reg    <= '0;
            len_b1_reg    <= '0;
            last1_reg     <= 1'b0;
            prev_kind_reg <= KIND_START;
            pos_a_reg     <= '0;
            pos_b_reg     <= '0;
            total_reg     <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_total_reg <= '0;
            out_err_reg   <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                v1_reg     <= s_axis_tvalid;
                op1_reg    <= op_t'(s_axis_tuser);
                kind1_reg  <= in_kind;
                len_a1_reg <= len_a_wide[LENGTH_BITS-1:0];
                len_b1_reg <= len_b_wide[LENGTH_BITS-1:0];
                last1_reg  <= s_axis_tlast;
            end

            if (score_col)
            begin
                if (last1_reg)
                begin
                    prev_kind_reg <= KIND_START;
                    pos_a_reg     <= '0;
                    pos_b_reg     <= '0;
                    total_reg     <= '0;
                    err_reg       <= 1'b0;
                end
                else
                begin
                    prev_kind_reg <= prev_kind_next;
                    pos_a_reg     <= pos_a_next;
                    pos_b_reg     <= pos_b_next;
                    total_reg     <= total_next;
                    err_reg       <= err_next;
                end
            end

            if (advance)
            begin
                out_valid_reg <= score_col && last1_reg;
                out_total_reg <= total_next;
                out_err_reg   <= err_next;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_total_reg;
    assign m_axis_tuser  = out_err_reg;

endmodule

@@ bench/alignment_path_scorer_tb.sv @@
// Self-checking bench for the alignment path scorer: column stimulus, score prediction, checks.
module alignment_path_scorer_tb;

    import aps_pkg::*;

    typedef struct {
        op_t         op;
        kind_t       kind;
        logic [4:0]  res_a;
        logic [4:0]  res_b;
        logic [15:0] len_a;
        logic [15:0] len_b;
        logic        last;
        logic [15:0] mval;
    } column_t;

    typedef struct {
        logic [31:0] total;
        logic        err;
    } path_score_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

    // stimulus side
    column_t     pending_columns[$];
    column_t     next_col;
    int          queued_count;
    int          accepted_count;
    int          src_gap;
    int          sink_gap;
    bit          idle_on = 1'b1;
    bit          loaded_map[1024];
    int          loaded_list[$];

    // predicted path state
    path_score_t expected_scores[$];
    column_t     taken;
    logic [31:0] penalty_regs[NUM_REGS];
    logic signed [15:0] sub_table[1024];
    kind_t       path_prev = KIND_START;
    int          path_pos_a;
    int          path_pos_b;
    longint      path_total;
    bit          path_err;
    int          mismatch_count;

    alignment_path_scorer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic longint pen_half(logic [CFG_INDEX_BITS-1:0] idx, bit b_half);
        logic signed [15:0] h;
        h = b_half ? penalty_regs[idx][31:16] : penalty_regs[idx][15:0];
        return h;
    endfunction

    task automatic score_column(input column_t c);
        int          i;
        int          j;
        bit          bad;
        bit          a_left;
        bit          b_left;
        bit          a_end;
        bit          b_end;
        longint      gap;
        longint      sub;
        path_score_t r;
        if (c.op == OP_LOAD)
        begin
            sub_table[{c.res_a, c.res_b}] = c.mval;
            return;
        end
        i = path_pos_a;
        j = path_pos_b;
        a_left = (i == 0);
        b_left = (j == 0);
        // code 3 on a column means an invalid kind
        bad = (c.kind == KIND_START) ||
              (c.kind == KIND_MATCH && (i >= c.len_a || j >= c.len_b)) ||
              (c.kind == KIND_DELETE && i >= c.len_a) ||
              (c.kind == KIND_INSERT && j >= c.len_b);
        if (bad)
            path_err = 1'b1;
        else
        begin
            sub = 0;
            gap = 0;
            if (c.kind == KIND_MATCH)
            begin
                sub = sub_table[{c.res_a, c.res_b}];
                i++;
                j++;
            end
            else if (c.kind == KIND_DELETE)
                i++;
            else
                j++;
            a_end = (c.len_a != 0) && (i == c.len_a);
            b_end = (c.len_b != 0) && (j == c.len_b);
            if (path_prev == KIND_START && c.kind == KIND_DELETE)
                gap = pen_half(REG_LEFT_OPEN, 1'b1);
            else if (path_prev == KIND_START && c.kind == KIND_INSERT)
                gap = pen_half(REG_LEFT_OPEN, 1'b0);
            else if (path_prev == KIND_MATCH && c.kind == KIND_DELETE)
                gap = pen_half(b_end ? REG_RIGHT_OPEN : REG_INTERIOR_OPEN, 1'b1);
            else if (path_prev == KIND_MATCH && c.kind == KIND_INSERT)
                gap = pen_half(a_end ? REG_RIGHT_OPEN : REG_INTERIOR_OPEN, 1'b0);
            else if (path_prev == KIND_DELETE && c.kind == KIND_DELETE)
                gap = pen_half(b_left ? REG_LEFT_EXTEND :
                               (b_end ? REG_RIGHT_EXTEND : REG_INTERIOR_EXTEND), 1'b1);
            else if (path_prev == KIND_INSERT && c.kind == KIND_INSERT)
                gap = pen_half(a_left ? REG_LEFT_EXTEND :
                               (a_end ? REG_RIGHT_EXTEND : REG_INTERIOR_EXTEND), 1'b0);
            path_total = path_total + sub + gap;
            if (path_total > 64'sd2147483647)
                path_total = 64'sd2147483647;
            else if (path_total < -64'sd2147483648)
                path_total = -64'sd2147483648;
            path_pos_a = i;
            path_pos_b = j;
            path_prev = c.kind;
        end
        if (c.last)
        begin
            r.total = path_total[31:0];
            r.err = path_err;
            expected_scores.push_back(r);
            path_prev = KIND_START;
            path_pos_a = 0;
            path_pos_b = 0;
            path_total = 0;
            path_err = 1'b0;
        end
    endtask

    // driver: one item per handshake, random idle bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= 1'b0;
            s_axis_tlast <= 1'b0;
            src_gap = 0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (src_gap > 0)
            begin
                src_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 11) == 0)
            begin
                src_gap = $urandom_range(0, 15);
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_columns.size() > 0)
            begin
                next_col = pending_columns.pop_front();
                s_axis_tdata <= {4'b0, next_col.mval, next_col.len_b, next_col.len_a,
                                 next_col.res_b, next_col.res_a, next_col.kind};
                s_axis_tuser <= next_col.op;
                s_axis_tlast <= next_col.last;
                s_axis_tvalid <= 1'b1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // predict from what the block actually accepts
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            taken.op = op_t'(s_axis_tuser);
            taken.kind = kind_t'(s_axis_tdata[1:0]);
            taken.res_a = s_axis_tdata[6:2];
            taken.res_b = s_axis_tdata[11:7];
            taken.len_a = s_axis_tdata[27:12];
            taken.len_b = s_axis_tdata[43:28];
            taken.mval = s_axis_tdata[59:44];
            taken.last = s_axis_tlast;
            score_column(taken);
            accepted_count++;
        end
    end

    // result monitor with random back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            sink_gap = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_scores.size() == 0)
                begin
                    $display("%0t unexpected result: total_score %0d path_error %0b",
                             $time, $signed(m_axis_tdata), m_axis_tuser);
                    mismatch_count++;
                end
                else
                begin
                    path_score_t want;
                    want = expected_scores.pop_front();
                    if (m_axis_tdata !== want.total)
                    begin
                        $display("%0t total_score expected %0d actual %0d",
                                 $time, $signed(want.total), $signed(m_axis_tdata));
                        mismatch_count++;
                    end
                    if (m_axis_tuser !== want.err)
                    begin
                        $display("%0t path_error expected %0b actual %0b",
                                 $time, want.err, m_axis_tuser);
                        mismatch_count++;
                    end
                end
            end
            if (sink_gap > 0)
            begin
                sink_gap--;
                m_axis_tready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                sink_gap = $urandom_range(0, 15);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    task automatic queue_item(input column_t c);
        pending_columns.push_back(c);
        queued_count++;
    endtask

    task automatic push_load(input int idx, input logic [15:0] v);
        column_t c;
        c.op = OP_LOAD;
        c.kind = kind_t'($urandom_range(0, 3));
        c.res_a = idx[9:5];
        c.res_b = idx[4:0];
        c.len_a = 16'($urandom());
        c.len_b = 16'($urandom());
        c.last = 1'($urandom_range(0, 1));
        c.mval = v;
        queue_item(c);
        if (!loaded_map[idx])
        begin
            loaded_map[idx] = 1'b1;
            loaded_list.push_back(idx);
        end
    endtask

    // residues come only from entries already loaded
    function automatic column_t score_item(kind_t k, logic [15:0] la, logic [15:0] lb,
                                           logic last);
        column_t c;
        int      pick;
        pick = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
        c.op = OP_SCORE;
        c.kind = k;
        c.res_a = pick[9:5];
        c.res_b = pick[4:0];
        c.len_a = la;
        c.len_b = lb;
        c.last = last;
        c.mval = 16'($urandom());
        return c;
    endfunction

    function automatic bit can_take(kind_t k, int i, int j, int la, int lb);
        return (k == KIND_MATCH && i < la && j < lb) ||
               (k == KIND_DELETE && i < la) || (k == KIND_INSERT && j < lb);
    endfunction

    // M/D/I match, deletion, insertion; S an invalid column; L a table load
    task automatic push_plan(input int la, input int lb, input string plan);
        kind_t k;
        for (int n = 0; n < plan.len(); n++)
        begin
            if (plan[n] == "L")
                push_load(5 * 32 + 10, 16'($urandom()));
            else
            begin
                case (plan[n])
                    "M": k = KIND_MATCH;
                    "D": k = KIND_DELETE;
                    "I": k = KIND_INSERT;
                    default: k = KIND_START;
                endcase
                queue_item(score_item(k, la, lb, n == plan.len() - 1));
            end
        end
    endtask

    // well-formed random walk from the origin, cut short at max_cols
    task automatic push_walk(input int la, input int lb, input int max_cols);
        int    i;
        int    j;
        int    n;
        kind_t k;
        kind_t prev;
        bit    fin;
        i = 0;
        j = 0;
        n = 0;
        prev = KIND_START;
        while (n < max_cols && (i < la || j < lb))
        begin
            if (prev != KIND_START && $urandom_range(0, 1) == 1 && can_take(prev, i, j, la, lb))
                k = prev;
            else
            begin
                do
                    k = kind_t'($urandom_range(0, 2));
                while (!can_take(k, i, j, la, lb));
            end
            if (k != KIND_INSERT)
                i++;
            if (k != KIND_DELETE)
                j++;
            n++;
            fin = (n == max_cols) || (i == la && j == lb);
            queue_item(score_item(k, la, lb, fin));
            if (!fin && $urandom_range(0, 19) == 0)
                push_load($urandom_range(0, 1023), 16'($urandom()));
            prev = k;
        end
        if (n == 0)
            queue_item(score_item(kind_t'($urandom_range(0, 2)), la, lb, 1'b1));
    endtask

    task automatic push_random_mix(input int count);
        int goal;
        int r;
        int la;
        int lb;
        int n;
        goal = queued_count + count;
        while (queued_count < goal)
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
                push_load($urandom_range(0, 1023), ($urandom_range(0, 3) == 0) ?
                          ($urandom_range(0, 1) ? 16'h7FFF : 16'h8000) : 16'($urandom()));
            else if (r < 78)
            begin
                n = $urandom_range(0, 9);
                if (n < 7)
                    push_walk($urandom_range(0, 10), $urandom_range(0, 10), 40);
                else if (n < 9)
                    push_walk($urandom_range(1, 3), $urandom_range(1, 3), $urandom_range(1, 6));
                else
                begin
                    la = $urandom_range(0, 1) ? 65535 : $urandom_range(0, 65535);
                    lb = $urandom_range(0, 1) ? 65535 : $urandom_range(0, 65535);
                    push_walk(la, lb, $urandom_range(2, 12));
                end
            end
            else
            begin
                // broken columns: any kind, lengths that may not hold
                n = $urandom_range(1, 6);
                for (int m = 0; m < n; m++)
                begin
                    la = $urandom_range(0, 1) ? $urandom_range(0, 4) : $urandom_range(0, 65535);
                    lb = $urandom_range(0, 1) ? $urandom_range(0, 4) : $urandom_range(0, 65535);
                    queue_item(score_item(kind_t'($urandom_range(0, 3)), la, lb,
                               (m == n - 1) ? ($urandom_range(0, 9) != 0)
                                            : ($urandom_range(0, 15) == 0)));
                end
            end
        end
        // close any open path before the phase ends
        queue_item(score_item(kind_t'($urandom_range(0, 3)), $urandom_range(0, 8),
                              $urandom_range(0, 8), 1'b1));
    endtask

    // one match, a run of deletions and a tail of insertions, extreme values at the length limit
    task automatic push_extreme_path(input logic [15:0] v);
        column_t c;
        push_load(0, v);
        c = score_item(KIND_MATCH, 16'hFFFF, 16'hFFFF, 1'b0);
        c.res_a = '0;
        c.res_b = '0;
        queue_item(c);
        repeat (30)
            queue_item(score_item(KIND_DELETE, 16'hFFFF, 16'hFFFF, 1'b0));
        for (int n = 0; n < 12; n++)
            queue_item(score_item(KIND_INSERT, 16'hFFFF, 16'hFFFF, n == 11));
    endtask

    task automatic wait_quiet();
        while (accepted_count != queued_count || expected_scores.size() != 0)
            @(posedge clk);
        // a trailing load may still be in the pipe
        repeat (4) @(posedge clk);
    endtask

    task automatic set_penalty(input logic [CFG_INDEX_BITS-1:0] idx, input logic [31:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        penalty_regs[idx] = v;
    endtask

    task automatic load_penalty_set(input logic [31:0] iopen, input logic [31:0] lopen,
                                    input logic [31:0] ropen, input logic [31:0] iext,
                                    input logic [31:0] lext, input logic [31:0] rext);
        set_penalty(REG_INTERIOR_OPEN, iopen);
        set_penalty(REG_LEFT_OPEN, lopen);
        set_penalty(REG_RIGHT_OPEN, ropen);
        set_penalty(REG_INTERIOR_EXTEND, iext);
        set_penalty(REG_LEFT_EXTEND, lext);
        set_penalty(REG_RIGHT_EXTEND, rext);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] small_pair();
        return {16'($urandom_range(0, 128) - 64), 16'($urandom_range(0, 128) - 64)};
    endfunction

    initial
    begin
        for (int n = 0; n < NUM_REGS; n++)
            penalty_regs[n] = '0;
        for (int n = 0; n < 1024; n++)
            sub_table[n] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        load_penalty_set(32'hFFD0_FFE0, 32'hFFF8_FFFC, 32'hFFF4_FFF6,
                         32'hFFFE_FFFF, 32'h0001_0002, 32'hFFFD_FFFB);
        push_load(0, 16'h7FFF);
        push_load(31 * 32 + 31, 16'h8000);
        push_load(5 * 32 + 10, 16'h0010);
        push_load(31 * 32, 16'hFFFF);
        push_plan(4, 4, "DDMMIIM");
        push_plan(3, 3, "IIMDD");
        push_plan(5, 5, "MDDIMI");
        push_plan(0, 0, "M");
        push_plan(2, 2, "MSLM");
        wait_quiet();

        load_penalty_set('0, '0, '0, '0, '0, '0);
        push_random_mix(350);
        wait_quiet();
        load_penalty_set('1, '1, '1, '1, '1, '1);
        push_random_mix(350);
        wait_quiet();
        for (int p = 0; p < 2; p++)
        begin
            load_penalty_set(small_pair(), small_pair(), small_pair(),
                             small_pair(), small_pair(), small_pair());
            push_random_mix(350);
            wait_quiet();
        end
        load_penalty_set($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
        push_random_mix(350);
        wait_quiet();

        // closing stretch runs flat out
        idle_on = 1'b0;
        load_penalty_set(small_pair(), small_pair(), small_pair(),
                         small_pair(), small_pair(), small_pair());
        push_random_mix(100);
        wait_quiet();
        load_penalty_set(32'h7FFF_7FFF, 32'h7FFF_7FFF, 32'h7FFF_7FFF,
                         32'h7FFF_7FFF, 32'h7FFF_7FFF, 32'h7FFF_7FFF);
        push_extreme_path(16'h7FFF);
        wait_quiet();
        load_penalty_set(32'h8000_8000, 32'h8000_8000, 32'h8000_8000,
                         32'h8000_8000, 32'h8000_8000, 32'h8000_8000);
        push_extreme_path(16'h8000);
        wait_quiet();
        repeat (10) @(posedge clk);

        if (mismatch_count == 0 && expected_scores.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
